// File: hdl/button_reactive_led_fader_macros.svh
`ifndef BUTTON_REACTIVE_LED_FADER_MACROS_SVH
`define BUTTON_REACTIVE_LED_FADER_MACROS_SVH

// same-cycle implication, checked outside reset
`define BRLF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define BRLF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/brlf_pkg.sv
package brlf_pkg;

    localparam int unsigned CFG_LEDS   = 10;
    localparam int unsigned SRC_COUNT  = 18;
    localparam int unsigned SRC_W      = 5;
    localparam int unsigned MODE_W     = 2;
    localparam int unsigned NOW_W      = 32;
    localparam int unsigned MASK_W     = 18;
    localparam int unsigned LVL_W      = 8;
    localparam int unsigned IDX_OUT_W  = 4;
    localparam int unsigned DELAY_W    = 16;
    localparam int unsigned CFG_DATA_W = 50;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned S_TDATA_W  = 56;
    localparam int unsigned M_TDATA_W  = 16;

    localparam logic [LVL_W-1:0]   LVL_MAX        = 8'd255;
    localparam logic [DELAY_W-1:0] DELAY_RESET    = 16'd10;
    localparam logic [LVL_W-1:0]   STEP_RESET     = 8'd5;
    localparam logic [LVL_W-1:0]   FULL_RESET     = 8'd255;

    typedef enum logic [MODE_W-1:0] {
        MODE_OFF      = 2'd0,
        MODE_ON       = 2'd1,
        MODE_FADE_IN  = 2'd2,
        MODE_FADE_OUT = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LED_SOURCES   = 3'd0,
        REG_PRESS_MODES   = 3'd1,
        REG_RELEASE_MODES = 3'd2,
        REG_LED_ENABLES   = 3'd3,
        REG_FADE_DELAY    = 3'd4,
        REG_FADE_STEP     = 3'd5,
        REG_FULL_LEVEL    = 3'd6,
        REG_UNUSED        = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [49:0]        sources;
        logic [19:0]        press_modes;
        logic [19:0]        release_modes;
        logic [9:0]         enables;
        logic [DELAY_W-1:0] delay;
        logic [LVL_W-1:0]   step;
        logic [LVL_W-1:0]   full;
    } t_cfg;

    typedef struct packed {
        logic [LVL_W-1:0] level;
        logic [NOW_W-1:0] last_time;
        logic             was_pressed;
    } t_led_st;

endpackage

// File: hdl/button_reactive_led_fader.sv
// channel  | dir | tdata (low bit up)               | tlast
// s_axis   | in  | now_ms[31:0], pressed_mask[49:32] | -
// m_axis   | out | led_index[3:0], brightness[11:4] | last_led
// cfg      | in  | wr_en, index, wdata[49:0]         | -
//
// a tick starts with the accepting cycle, then one LED per cycle
// through the shared step unit; the accept moves to busy, and the first result is registered when busy advances
// output stalls hold the sequencer on the current LED, ready stays low while busy
// synchronous active-low reset clears levels, step times and press state
// a new tick is taken while the final result of the previous tick is still waiting
`include "button_reactive_led_fader_macros.svh"

module button_reactive_led_fader
    import brlf_pkg::*;
#(
    parameter int unsigned LED_COUNT = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,   // now_ms, pressed_mask
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [M_TDATA_W-1:0]  m_axis_tdata,   // led_index, brightness
    output logic                  m_axis_tlast,   // last_led
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int unsigned IDX_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LED_COUNT - 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_BUSY = 2'b10
    } t_state;

    t_state            r_state;
    logic [IDX_W-1:0]  r_idx;
    logic [NOW_W-1:0]  r_now;
    logic [MASK_W-1:0] r_mask;
    t_led_st           r_led [LED_COUNT];

    logic                 r_out_valid;
    logic [IDX_OUT_W-1:0] r_out_idx;
    logic [LVL_W-1:0]     r_out_lvl;
    logic                 r_out_last;

    t_cfg    cfg;
    t_led_st n_led;
    logic    s_fire;
    logic    advance;

    brlf_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    brlf_step_unit u_step (
        .i_cfg  (cfg),
        .i_led  (IDX_OUT_W'(r_idx)),
        .i_now  (r_now),
        .i_mask (r_mask),
        .i_st   (r_led[r_idx]),
        .o_st   (n_led)
    );

    assign s_axis_tready = (r_state == ST_IDLE);
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign advance       = (r_state == ST_BUSY) && (!r_out_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < LED_COUNT; i++) begin
                r_led[i] <= '0;
            end
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (m_axis_tready) begin
                        r_out_valid <= 1'b0;
                    end
                    if (s_fire) begin
                        r_idx   <= '0;
                        r_state <= ST_BUSY;
                    end
                end
                ST_BUSY: begin
                    if (advance) begin
                        r_led[r_idx] <= n_led;
                        r_out_valid  <= 1'b1;
                        if (r_idx == LAST_IDX) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_now  <= s_axis_tdata[NOW_W-1:0];
            r_mask <= s_axis_tdata[NOW_W+MASK_W-1:NOW_W];
        end
        if (advance) begin
            r_out_idx  <= IDX_OUT_W'(r_idx);
            r_out_lvl  <= n_led.level;
            r_out_last <= (r_idx == LAST_IDX);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(M_TDATA_W-IDX_OUT_W-LVL_W){1'b0}}, r_out_lvl, r_out_idx};
    assign m_axis_tlast  = r_out_last;

    `BRLF_ASSERT_NEXT(a_start_led0, i_clk, i_rst_n, s_fire, (r_state == ST_BUSY) && (r_idx == '0), "tick did not start at led 0")
    `BRLF_ASSERT_IMPL(a_last_idx, i_clk, i_rst_n, m_axis_tvalid && m_axis_tlast, r_out_idx == IDX_OUT_W'(LED_COUNT - 1), "last flag on wrong led")
    `BRLF_ASSERT_IMPL(a_idx_range, i_clk, i_rst_n, r_state == ST_BUSY, r_idx <= LAST_IDX, "led index out of range")

endmodule

// File: hdl/brlf_cfg_regs.sv
module brlf_cfg_regs
    import brlf_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sources       <= '0;
            r_cfg.press_modes   <= '0;
            r_cfg.release_modes <= '0;
            r_cfg.enables       <= '0;
            r_cfg.delay         <= DELAY_RESET;
            r_cfg.step          <= STEP_RESET;
            r_cfg.full          <= FULL_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_LED_SOURCES:   r_cfg.sources       <= i_cfg_wdata;
                REG_PRESS_MODES:   r_cfg.press_modes   <= i_cfg_wdata[19:0];
                REG_RELEASE_MODES: r_cfg.release_modes <= i_cfg_wdata[19:0];
                REG_LED_ENABLES:   r_cfg.enables       <= i_cfg_wdata[9:0];
                REG_FADE_DELAY:    r_cfg.delay         <= i_cfg_wdata[DELAY_W-1:0];
                REG_FADE_STEP:     r_cfg.step          <= i_cfg_wdata[LVL_W-1:0];
                REG_FULL_LEVEL:    r_cfg.full          <= i_cfg_wdata[LVL_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: hdl/brlf_step_unit.sv
module brlf_step_unit
    import brlf_pkg::*;
(
    input  t_cfg                 i_cfg,
    input  logic [IDX_OUT_W-1:0] i_led,
    input  logic [NOW_W-1:0]     i_now,
    input  logic [MASK_W-1:0]    i_mask,
    input  t_led_st              i_st,
    output t_led_st              o_st
);

    logic [SRC_W-1:0]  src;
    logic              en;
    logic              active;
    logic [MASK_W-1:0] mask_sh;
    logic              pr;
    logic [19:0]       mode_vec;
    t_mode             mode;
    logic [NOW_W-1:0]  elapsed;
    logic              due;
    logic              changed;
    logic [LVL_W-1:0]  base;
    logic [LVL_W:0]    sum;
    logic [LVL_W-1:0]  fade_lvl;

    assign src     = SRC_W'(i_cfg.sources >> (6'(i_led) * 6'd5));
    assign en      = 1'(i_cfg.enables >> i_led);
    assign active  = en && (src != '0) && (src <= SRC_W'(SRC_COUNT));
    assign mask_sh = i_mask >> (src - 5'd1);
    assign pr      = mask_sh[0];
    assign mode_vec = pr ? i_cfg.press_modes : i_cfg.release_modes;
    assign mode    = t_mode'(MODE_W'(mode_vec >> (5'(i_led) * 5'd2)));
    assign elapsed = i_now - i_st.last_time;
    assign due     = elapsed >= {{(NOW_W-DELAY_W){1'b0}}, i_cfg.delay};
    assign changed = i_st.was_pressed != pr;

    // one adder shared by both fade directions
    always_comb begin
        base     = i_st.level;
        sum      = '0;
        fade_lvl = i_st.level;
        if (mode == MODE_FADE_IN) begin
            base = changed ? '0 : i_st.level;
            sum  = {1'b0, base} + {1'b0, i_cfg.step};
            if (base < i_cfg.full) begin
                fade_lvl = sum[LVL_W] ? LVL_MAX : sum[LVL_W-1:0];
            end else begin
                fade_lvl = base;
            end
        end else begin
            base = changed ? i_cfg.full : i_st.level;
            sum  = {1'b0, base} - {1'b0, i_cfg.step};
            fade_lvl = sum[LVL_W] ? '0 : sum[LVL_W-1:0];
        end
    end

    always_comb begin
        o_st = i_st;
        if (active) begin
            o_st.was_pressed = pr;
            unique case (mode)
                MODE_OFF: o_st.level = '0;
                MODE_ON:  o_st.level = LVL_MAX;
                MODE_FADE_IN, MODE_FADE_OUT: begin
                    if (due) begin
                        o_st.level     = fade_lvl;
                        o_st.last_time = i_now;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule
